// ===== rtl/cbd_pkg.sv =====
// Shared types and constants for the coded-picture buffer delay block.
package cbd_pkg;

    // Width of one frame size in bytes and of the drain scale factor.
    localparam int BYTES_W   = 24;
    localparam int SCALE_W   = 23;
    localparam int PRODUCT_W = BYTES_W + SCALE_W;
    localparam int LEVEL_W   = 32;
    localparam int PERIOD_W  = 24;
    localparam int RATE_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Bits per byte times microseconds per second.
    localparam logic [SCALE_W-1:0] DRAIN_SCALE = 23'd8000000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd3;

    // Configuration values after reset.
    localparam logic                RST_ENABLE     = 1'b1;
    localparam logic [RATE_W-1:0]   RST_BIT_RATE   = 32'd1000000;
    localparam logic [LEVEL_W-1:0]  RST_BUFFER_LEN = 32'd1000000;
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 24'd40000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_FINISH
    } cbd_state_t;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } cbd_div_stat_t;

endpackage

// ===== rtl/cbd_div.sv =====
// Radix-2 restoring serial divider, one quotient bit per cycle.
module cbd_div #(
    parameter int DVD_W = 47,
    parameter int DVS_W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DVD_W-1:0]     dividend,
    input  logic [DVS_W-1:0]     divisor,
    output cbd_pkg::cbd_div_stat_t stat,
    output logic [DVD_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    // The dividend register shifts out its top bit and takes the quotient bit in.
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DVD_W);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
            rem_next  = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_next  = {quo_reg[DVD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== rtl/cpb_leaky_bucket_delay.sv =====
// Top level of the coded-picture buffer leaky-bucket delay block.
//
// Each request on the input channel (in_valid/in_ready) carries one coded
// frame: its size in bytes and an intra flag. Each one yields exactly one
// request on the output channel (out_valid/out_ready) with the delay in
// microseconds, a valid flag and underflow/overflow flags.
// A frame that enters the model passes these steps after acceptance: scale
// the byte count, start the divider, wait in the radix-2 serial divider,
// see the divider finish, and clamp and update the level. Frames that are
// passed through (block disabled, or no intra frame seen yet) skip the
// scaling and the divider and go straight to loading the output register.
// One frame is handled at a time: the next is not accepted before the last
// has been loaded into the output register.
// The result sits in an output register; the next frame is accepted while it
// waits, and a stalled receiver only holds the block once a second result is
// ready. Reset clears the buffer level, forgets any intra frame seen and
// loads the default configuration. Configuration writes on cfg_we/cfg_addr/
// cfg_wdata take effect at once and are meant for an idle block.
module cpb_leaky_bucket_delay (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cbd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [cbd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cbd_pkg::BYTES_W-1:0]   frame_bytes,
    input  logic                          is_intra,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cbd_pkg::LEVEL_W-1:0]   delay_us,
    output logic                          delay_valid,
    output logic                          underflow,
    output logic                          overflow
);

    localparam int PW = cbd_pkg::PRODUCT_W;
    localparam int LW = cbd_pkg::LEVEL_W;

    // Configuration registers.
    logic                            enable_reg;
    logic [cbd_pkg::RATE_W-1:0]      bit_rate_reg;
    logic [LW-1:0]                   length_reg;
    logic [cbd_pkg::PERIOD_W-1:0]    period_reg;

    // Sequencer and model state.
    cbd_pkg::cbd_state_t state_reg, state_next;
    logic                started_reg, started_next;
    logic [LW-1:0]       level_reg, level_next;
    logic                bypass_reg, bypass_next;

    // Frame data and scaled byte count.
    logic [cbd_pkg::BYTES_W-1:0] bytes_reg, bytes_next;
    logic [PW-1:0]               product_reg, product_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic [LW-1:0] delay_reg, delay_next;
    logic          dvalid_reg, dvalid_next;
    logic          under_reg, under_next;
    logic          over_reg, over_next;

    // Sequencer outputs.
    logic accept;
    logic mul_en;
    logic div_start;
    logic load_out;

    cbd_pkg::cbd_div_stat_t div_stat;
    logic [PW-1:0]          quotient;

    // Level update.
    logic [LW:0]   gained;
    logic [LW:0]   remain;
    logic          drain_over;
    logic          fill_over;
    logic [LW-1:0] new_level;
    logic          out_free;

    cbd_div #(
        .DVD_W (PW),
        .DVS_W (cbd_pkg::RATE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (bit_rate_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bypass_next ? cbd_pkg::ST_FINISH : cbd_pkg::ST_MUL;
                end
            end
            cbd_pkg::ST_MUL:
            begin
                state_next = cbd_pkg::ST_START;
            end
            cbd_pkg::ST_START:
            begin
                state_next = cbd_pkg::ST_WAIT;
            end
            cbd_pkg::ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = cbd_pkg::ST_FINISH;
                end
            end
            cbd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = cbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbd_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        mul_en    = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            cbd_pkg::ST_IDLE:   in_ready  = 1'b1;
            cbd_pkg::ST_MUL:    mul_en    = 1'b1;
            cbd_pkg::ST_START:  div_start = 1'b1;
            cbd_pkg::ST_WAIT:   ;
            cbd_pkg::ST_FINISH: load_out  = out_free;
            default:            ;
        endcase
    end

    assign accept = in_valid && in_ready;

    // The drain in microseconds is the quotient; a level below zero clamps to
    // zero, and one above the full length clamps to the length.
    assign gained     = {1'b0, level_reg} + {{(LW + 1 - cbd_pkg::PERIOD_W){1'b0}}, period_reg};
    assign drain_over = (quotient > {{(PW - LW - 1){1'b0}}, gained});
    assign remain     = gained - quotient[LW:0];
    assign fill_over  = !drain_over && (remain > {1'b0, length_reg});

    always_comb
    begin
        if (drain_over)
        begin
            new_level = '0;
        end
        else if (fill_over)
        begin
            new_level = length_reg;
        end
        else
        begin
            new_level = remain[LW-1:0];
        end
    end

    // Frame acceptance, level update and output register.
    always_comb
    begin
        bypass_next    = !enable_reg || (!started_reg && !is_intra);
        started_next   = started_reg;
        level_next     = level_reg;
        bytes_next     = bytes_reg;
        product_next   = product_reg;
        out_valid_next = out_valid_reg;
        delay_next     = delay_reg;
        dvalid_next    = dvalid_reg;
        under_next     = under_reg;
        over_next      = over_reg;

        if (accept)
        begin
            bytes_next = frame_bytes;
            // The first intra frame fills the bucket before its own drain.
            if (!bypass_next && !started_reg)
            begin
                started_next = 1'b1;
                level_next   = length_reg;
            end
        end

        if (mul_en)
        begin
            product_next = PW'(bytes_reg) * PW'(cbd_pkg::DRAIN_SCALE);
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            if (bypass_reg)
            begin
                delay_next  = '0;
                dvalid_next = 1'b0;
                under_next  = 1'b0;
                over_next   = 1'b0;
            end
            else
            begin
                level_next  = new_level;
                delay_next  = new_level;
                dvalid_next = 1'b1;
                under_next  = drain_over;
                over_next   = fill_over;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbd_pkg::ST_IDLE;
            started_reg   <= 1'b0;
            level_reg     <= '0;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= cbd_pkg::RST_ENABLE;
            bit_rate_reg  <= cbd_pkg::RST_BIT_RATE;
            length_reg    <= cbd_pkg::RST_BUFFER_LEN;
            period_reg    <= cbd_pkg::RST_PERIOD;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                bypass_reg <= bypass_next;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    cbd_pkg::CFG_ENABLE:     enable_reg   <= cfg_wdata[0];
                    cbd_pkg::CFG_BIT_RATE:   bit_rate_reg <= cfg_wdata;
                    cbd_pkg::CFG_BUFFER_LEN: length_reg   <= cfg_wdata;
                    cbd_pkg::CFG_PERIOD:     period_reg   <= cfg_wdata[cbd_pkg::PERIOD_W-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg   <= bytes_next;
        product_reg <= product_next;
        delay_reg   <= delay_next;
        dvalid_reg  <= dvalid_next;
        under_reg   <= under_next;
        over_reg    <= over_next;
    end

    assign out_valid   = out_valid_reg;
    assign delay_us    = delay_reg;
    assign delay_valid = dvalid_reg;
    assign underflow   = under_reg;
    assign overflow    = over_reg;

    // One frame at a time: after an acceptance the input side closes.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a frame was in progress");

    // The divider is never restarted while it is still working.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A clamp goes one way only.
    a_one_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(underflow && overflow))
        else $error("underflow and overflow flagged together");

    // A frame without a delay carries no delay and no flags.
    a_bypass_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !delay_valid |-> delay_us == '0 && !underflow && !overflow)
        else $error("passed-through frame carries a delay or a flag");

endmodule
